/* hdl/abst_pkg.sv */
package abst_pkg;

  localparam int IN_KEY_W = 16;
  localparam int SLOT_IDX_W = 8;
  localparam int HEIGHT_W = 4;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_HEIGHT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOC_RD,
    S_LOC_CMP,
    S_DEL_RDL,
    S_DEL_CHKL,
    S_DEL_CHKR,
    S_CH_RD,
    S_CH_CMP,
    S_LM_RD,
    S_LM_CMP,
    S_FINISH
  } back_state_t;

  // Head of the request queue, as seen by the back end.
  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [IN_KEY_W-1:0] key;
  } q_item_t;

  // Back end control toward the front end.
  typedef struct packed {
    logic pop;
    logic accept_en;
  } bk_stat_t;

endpackage

/* hdl/abst_if.sv */
interface abst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] key;

  modport source (output valid, output kind, output key, input ready);
  modport sink (input valid, input kind, input key, output ready);
endinterface

interface abst_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [7:0]        slot_index;
  logic signed [3:0] tree_height;

  modport source (output valid, output status, output slot_index, output tree_height,
                  input ready);
  modport sink (input valid, input status, input slot_index, input tree_height,
                output ready);
endinterface

/* hdl/array_binary_search_tree.sv */
// An item descends the tree level by level from acceptance to result, reading and comparing
// one slot per level. A delete that hits then probes the children and walks the child chain
// or the successor path slot by slot. One item is worked at a time.
// After a synchronous reset (rst_n low) a clearing pass zeroes the occupancy memory; no item
// is accepted until it completes.
module array_binary_search_tree #(
  parameter int LEVELS   = 8,
  parameter int KEY_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  abst_in_if.sink    in_ch,
  abst_out_if.source out_ch
);

  abst_pkg::bk_stat_t stat;
  abst_pkg::q_item_t  head;

  abst_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .stat  (stat),
    .head  (head)
  );

  abst_back #(.LEVELS(LEVELS), .KEY_BITS(KEY_BITS)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .stat   (stat),
    .out_ch (out_ch)
  );

endmodule

/* hdl/abst_ram.sv */
module abst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/abst_front.sv */
module abst_front (
  input  logic                clk,
  input  logic                rst_n,
  abst_in_if.sink             in_ch,
  input  abst_pkg::bk_stat_t  stat,
  output abst_pkg::q_item_t   head
);

  typedef struct packed {
    abst_pkg::op_t                 op;
    logic [abst_pkg::IN_KEY_W-1:0] key;
  } entry_t;

  entry_t     ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign in_ch.ready = (cnt_r != 2'd2) && stat.accept_en;
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = stat.pop && (cnt_r != 2'd0);

  assign head.valid = (cnt_r != 2'd0);
  assign head.op    = ent_r[rd_ptr_r].op;
  assign head.key   = ent_r[rd_ptr_r].key;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // The request kind maps straight onto the operation code.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r].op  <= abst_pkg::op_t'(in_ch.kind);
      ent_r[wr_ptr_r].key <= in_ch.key;
    end
  end

endmodule

/* hdl/abst_back.sv */
module abst_back #(
  parameter int LEVELS   = 8,
  parameter int KEY_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  abst_pkg::q_item_t  head,
  output abst_pkg::bk_stat_t stat,
  abst_out_if.source         out_ch
);

  localparam int AW  = LEVELS;
  localparam int SW  = LEVELS + 1;
  localparam int LVW = $clog2(LEVELS);
  localparam int SLOTS = 1 << LEVELS;

  abst_pkg::back_state_t state_r, state_nxt;
  abst_pkg::op_t         op_r, op_nxt;
  abst_pkg::status_t     status_r, status_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [KEY_BITS-1:0]   kj_r, kj_nxt;
  logic [SW-1:0]         s_r, s_nxt;
  logic [SW-1:0]         c_r, c_nxt;
  logic [SW-1:0]         j_r, j_nxt;
  logic                  side_r, side_nxt;
  logic                  hl_r, hl_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic [AW-1:0]         cnt_r [LEVELS];
  logic [AW-1:0]         cnt_nxt [LEVELS];

  logic                            out_valid_r, out_valid_nxt;
  abst_pkg::status_t               out_status_r;
  logic [abst_pkg::SLOT_IDX_W-1:0] out_slot_r;
  logic signed [abst_pkg::HEIGHT_W-1:0] out_height_r;
  logic signed [abst_pkg::HEIGHT_W-1:0] height;
  logic                            load;

  logic [AW-1:0]       rd_addr;
  logic [KEY_BITS-1:0] key_q;
  logic [0:0]          used_q;
  logic                key_we;
  logic [AW-1:0]       key_waddr;
  logic [KEY_BITS-1:0] key_wdata;
  logic                used_we;
  logic [AW-1:0]       used_waddr;
  logic [0:0]          used_wdata;
  logic                upd_inc;
  logic                upd_dec;
  logic [AW-1:0]       upd_slot;
  logic [LVW-1:0]      upd_lvl;

  logic [SW-1:0] l_slot;
  logic [SW-1:0] r_slot;
  logic [SW-1:0] ch_n;
  logic [SW-1:0] lm_n;

  function automatic logic [LVW-1:0] slot_level(input logic [AW-1:0] a);
    logic [LVW-1:0] lv;
    lv = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (a[i]) begin
        lv = LVW'(i);
      end
    end
    return lv;
  endfunction

  abst_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_keys (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (rd_addr),
    .rdata (key_q)
  );

  abst_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .raddr (rd_addr),
    .rdata (used_q)
  );

  assign l_slot  = {s_r[AW-1:0], 1'b0};
  assign r_slot  = {s_r[AW-1:0], 1'b1};
  assign ch_n    = {c_r[AW-1:0], side_r};
  assign lm_n    = {j_r[AW-1:0], 1'b0};
  assign upd_lvl = slot_level(upd_slot);

  assign stat.accept_en = (state_r != abst_pkg::S_CLEAR);
  assign stat.pop       = (state_r == abst_pkg::S_IDLE) && head.valid;

  // Height is the deepest level whose occupancy count is nonzero.
  always_comb begin
    height = '1;
    for (int i = 0; i < LEVELS; i++) begin
      if (cnt_r[i] != '0) begin
        height = abst_pkg::HEIGHT_W'(i);
      end
    end
  end

  assign load = (state_r == abst_pkg::S_FINISH) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    key_nxt    = key_r;
    kj_nxt     = kj_r;
    s_nxt      = s_r;
    c_nxt      = c_r;
    j_nxt      = j_r;
    side_nxt   = side_r;
    hl_nxt     = hl_r;
    clr_nxt    = clr_r;
    rd_addr    = s_r[AW-1:0];
    key_we     = 1'b0;
    key_waddr  = s_r[AW-1:0];
    key_wdata  = key_r;
    used_we    = 1'b0;
    used_waddr = s_r[AW-1:0];
    used_wdata = 1'b0;
    upd_inc    = 1'b0;
    upd_dec    = 1'b0;
    upd_slot   = s_r[AW-1:0];

    case (state_r)
      abst_pkg::S_CLEAR: begin
        used_we    = 1'b1;
        used_waddr = clr_r;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = abst_pkg::S_IDLE;
        end
      end
      abst_pkg::S_IDLE: begin
        if (head.valid) begin
          op_nxt     = head.op;
          key_nxt    = KEY_BITS'(head.key);
          s_nxt      = SW'(1);
          status_nxt = abst_pkg::ST_DONE;
          if (head.op == abst_pkg::OP_HEIGHT) begin
            s_nxt     = '0;
            state_nxt = abst_pkg::S_FINISH;
          end else begin
            state_nxt = abst_pkg::S_LOC_RD;
          end
        end
      end
      abst_pkg::S_LOC_RD: begin
        if (s_r[AW]) begin
          // The descent left the store.
          status_nxt = (op_r == abst_pkg::OP_INSERT) ? abst_pkg::ST_FULL : abst_pkg::ST_MISS;
          s_nxt      = '0;
          state_nxt  = abst_pkg::S_FINISH;
        end else begin
          state_nxt = abst_pkg::S_LOC_CMP;
        end
      end
      abst_pkg::S_LOC_CMP: begin
        if (!used_q[0]) begin
          if (op_r == abst_pkg::OP_INSERT) begin
            key_we     = 1'b1;
            used_we    = 1'b1;
            used_wdata = 1'b1;
            upd_inc    = 1'b1;
          end else begin
            status_nxt = abst_pkg::ST_MISS;
            s_nxt      = '0;
          end
          state_nxt = abst_pkg::S_FINISH;
        end else if (key_q == key_r) begin
          case (op_r)
            abst_pkg::OP_INSERT: begin
              status_nxt = abst_pkg::ST_DUP;
              state_nxt  = abst_pkg::S_FINISH;
            end
            abst_pkg::OP_DELETE: begin
              state_nxt = abst_pkg::S_DEL_RDL;
            end
            default: begin
              state_nxt = abst_pkg::S_FINISH;
            end
          endcase
        end else begin
          s_nxt     = {s_r[AW-1:0], (key_r > key_q)};
          state_nxt = abst_pkg::S_LOC_RD;
        end
      end
      abst_pkg::S_DEL_RDL: begin
        if (l_slot[AW]) begin
          // Bottom level: no children, so the slot is just cleared.
          used_we   = 1'b1;
          upd_dec   = 1'b1;
          state_nxt = abst_pkg::S_FINISH;
        end else begin
          rd_addr   = l_slot[AW-1:0];
          state_nxt = abst_pkg::S_DEL_CHKL;
        end
      end
      abst_pkg::S_DEL_CHKL: begin
        hl_nxt    = used_q[0];
        rd_addr   = r_slot[AW-1:0];
        state_nxt = abst_pkg::S_DEL_CHKR;
      end
      abst_pkg::S_DEL_CHKR: begin
        kj_nxt = key_q;
        if (hl_r && used_q[0]) begin
          j_nxt     = r_slot;
          state_nxt = abst_pkg::S_LM_RD;
        end else begin
          // One child or none: pull the chain on the occupied side up one step.
          side_nxt  = used_q[0];
          c_nxt     = s_r;
          state_nxt = abst_pkg::S_CH_RD;
        end
      end
      abst_pkg::S_CH_RD: begin
        if (ch_n[AW]) begin
          used_we    = 1'b1;
          used_waddr = c_r[AW-1:0];
          upd_dec    = 1'b1;
          upd_slot   = c_r[AW-1:0];
          state_nxt  = abst_pkg::S_FINISH;
        end else begin
          rd_addr   = ch_n[AW-1:0];
          state_nxt = abst_pkg::S_CH_CMP;
        end
      end
      abst_pkg::S_CH_CMP: begin
        if (used_q[0]) begin
          key_we    = 1'b1;
          key_waddr = c_r[AW-1:0];
          key_wdata = key_q;
          c_nxt     = ch_n;
          state_nxt = abst_pkg::S_CH_RD;
        end else begin
          used_we    = 1'b1;
          used_waddr = c_r[AW-1:0];
          upd_dec    = 1'b1;
          upd_slot   = c_r[AW-1:0];
          state_nxt  = abst_pkg::S_FINISH;
        end
      end
      abst_pkg::S_LM_RD: begin
        if (lm_n[AW]) begin
          key_we     = 1'b1;
          key_wdata  = kj_r;
          used_we    = 1'b1;
          used_waddr = j_r[AW-1:0];
          upd_dec    = 1'b1;
          upd_slot   = j_r[AW-1:0];
          state_nxt  = abst_pkg::S_FINISH;
        end else begin
          rd_addr   = lm_n[AW-1:0];
          state_nxt = abst_pkg::S_LM_CMP;
        end
      end
      abst_pkg::S_LM_CMP: begin
        if (used_q[0]) begin
          j_nxt     = lm_n;
          kj_nxt    = key_q;
          state_nxt = abst_pkg::S_LM_RD;
        end else begin
          // The successor's right branch stays behind, unreachable.
          key_we     = 1'b1;
          key_wdata  = kj_r;
          used_we    = 1'b1;
          used_waddr = j_r[AW-1:0];
          upd_dec    = 1'b1;
          upd_slot   = j_r[AW-1:0];
          state_nxt  = abst_pkg::S_FINISH;
        end
      end
      abst_pkg::S_FINISH: begin
        if (load) begin
          state_nxt = abst_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = abst_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (upd_lvl == LVW'(i)) begin
        if (upd_inc) begin
          cnt_nxt[i] = cnt_r[i] + 1'b1;
        end else if (upd_dec) begin
          cnt_nxt[i] = cnt_r[i] - 1'b1;
        end
      end
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= abst_pkg::S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < LEVELS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    status_r <= status_nxt;
    key_r    <= key_nxt;
    kj_r     <= kj_nxt;
    s_r      <= s_nxt;
    c_r      <= c_nxt;
    j_r      <= j_nxt;
    side_r   <= side_nxt;
    hl_r     <= hl_nxt;
    if (load) begin
      out_status_r <= status_r;
      out_slot_r   <= abst_pkg::SLOT_IDX_W'(s_r);
      out_height_r <= height;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.slot_index  = out_slot_r;
  assign out_ch.tree_height = out_height_r;

`ifndef NO_ASSERTIONS
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == abst_pkg::S_CLEAR) |-> !stat.pop)
    else $error("request taken during clearing pass");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (state_r == abst_pkg::S_IDLE) && out_valid_r)
    else $error("result load did not return to idle");

  a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == abst_pkg::ST_FULL || out_status_r == abst_pkg::ST_MISS))
      |-> (out_slot_r == '0))
    else $error("miss or full result carries a slot");

  a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
    !(upd_inc && upd_dec))
    else $error("occupancy count raised and lowered at once");
`endif

endmodule

/* dv/tb_array_binary_search_tree.sv */
`timescale 1ns / 100ps

module tb_array_binary_search_tree;

  localparam int NSLOT = 256;

  typedef struct packed {
    abst_pkg::status_t status;
    logic [7:0]        slot_index;
    logic signed [3:0] tree_height;
  } tree_result_t;

  typedef struct {
    abst_pkg::op_t     op;
    logic [15:0]       key;
    logic              typed;
    abst_pkg::status_t st;
    logic [7:0]        slot;
    int                ht;
  } dir_row_t;

  logic clk;
  logic rst_n;

  abst_in_if  in_ch ();
  abst_out_if out_ch ();

  array_binary_search_tree i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Shadow copy of the slot store.
  logic [15:0]  shadow_key [NSLOT];
  logic         shadow_used [NSLOT];
  tree_result_t pending_results [$];
  int           errors;
  int           results_seen;
  int           ops_sent [4];
  bit           calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit slot_taken(int s);
    return s < NSLOT && shadow_used[s];
  endfunction

  function automatic int find_slot(logic [15:0] key, output bit hit);
    int s;
    s = 1;
    hit = 1'b0;
    while (slot_taken(s)) begin
      if (shadow_key[s] == key) begin
        hit = 1'b1;
        return s;
      end
      s = (key < shadow_key[s]) ? 2 * s : 2 * s + 1;
    end
    return s;
  endfunction

  function automatic void delete_slot(int s);
    int c;
    int side;
    int j;
    bit hl;
    bit hr;
    hl = slot_taken(2 * s);
    hr = slot_taken(2 * s + 1);
    if (!hl && !hr) begin
      shadow_used[s] = 1'b0;
    end else if (!hl || !hr) begin
      side = hl ? 0 : 1;
      c = 2 * s + side;
      shadow_key[s] = shadow_key[c];
      while (slot_taken(2 * c + side)) begin
        shadow_key[c] = shadow_key[2 * c + side];
        c = 2 * c + side;
      end
      shadow_used[c] = 1'b0;
    end else begin
      j = 2 * s + 1;
      while (slot_taken(2 * j)) j = 2 * j;
      shadow_key[s] = shadow_key[j];
      shadow_used[j] = 1'b0;
    end
  endfunction

  function automatic logic signed [3:0] deepest_level();
    int deepest;
    int h;
    deepest = 0;
    h = -1;
    for (int s = 1; s < NSLOT; s++) if (shadow_used[s]) deepest = s;
    while (deepest > 0) begin
      deepest = deepest >> 1;
      h++;
    end
    return h[3:0];
  endfunction

  function automatic tree_result_t apply_request(abst_pkg::op_t op, logic [15:0] key);
    tree_result_t r;
    int s;
    bit hit;
    r.status = abst_pkg::ST_DONE;
    r.slot_index = '0;
    if (op != abst_pkg::OP_HEIGHT) begin
      s = find_slot(key, hit);
      case (op)
        abst_pkg::OP_INSERT: begin
          if (hit) begin
            r.status = abst_pkg::ST_DUP;
            r.slot_index = s[7:0];
          end else if (s >= NSLOT) begin
            r.status = abst_pkg::ST_FULL;
          end else begin
            shadow_key[s] = key;
            shadow_used[s] = 1'b1;
            r.slot_index = s[7:0];
          end
        end
        abst_pkg::OP_DELETE: begin
          if (hit) begin
            delete_slot(s);
            r.slot_index = s[7:0];
          end else begin
            r.status = abst_pkg::ST_MISS;
          end
        end
        default: begin
          if (hit) r.slot_index = s[7:0];
          else r.status = abst_pkg::ST_MISS;
        end
      endcase
    end
    r.tree_height = deepest_level();
    return r;
  endfunction

  // Drives one item, holding valid until it is taken, with random gaps. Valid stays high
  // after the item is taken so that a following item can go out in the next cycle.
  task automatic send_request(abst_pkg::op_t op, logic [15:0] key);
    while (!calm && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= op;
    in_ch.key   <= key;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_request(op, key));
    ops_sent[op]++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Result ready with random stalls.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    tree_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d slot=%0d height=%0d", $time,
                 out_ch.status, out_ch.slot_index, out_ch.tree_height);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status || out_ch.slot_index !== want.slot_index ||
            out_ch.tree_height !== want.tree_height) begin
          $display("%0t: expected status=%0d slot=%0d height=%0d, got %0d %0d %0d",
                   $time, want.status, want.slot_index, want.tree_height,
                   out_ch.status, out_ch.slot_index, out_ch.tree_height);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t    rows [$];
    dir_row_t    row;
    tree_result_t got;
    logic [15:0] key;
    logic [15:0] base;
    int          n;
    int          waited;

    errors = 0;
    results_seen = 0;
    calm = 1'b0;
    foreach (ops_sent[i]) ops_sent[i] = 0;
    foreach (shadow_used[i]) begin
      shadow_used[i] = 1'b0;
      shadow_key[i] = '0;
    end
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = abst_pkg::OP_HEIGHT;
    in_ch.key = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Typed rows after reset and at key extremes; the rest use the predictor.
    rows.push_back('{abst_pkg::OP_HEIGHT, 16'h0000, 1'b1, abst_pkg::ST_DONE, 8'd0, -1});
    rows.push_back('{abst_pkg::OP_SEARCH, 16'h1234, 1'b1, abst_pkg::ST_MISS, 8'd0, -1});
    rows.push_back('{abst_pkg::OP_DELETE, 16'h1234, 1'b1, abst_pkg::ST_MISS, 8'd0, -1});
    rows.push_back('{abst_pkg::OP_INSERT, 16'h8000, 1'b1, abst_pkg::ST_DONE, 8'd1, 0});
    rows.push_back('{abst_pkg::OP_INSERT, 16'h8000, 1'b1, abst_pkg::ST_DUP, 8'd1, 0});
    rows.push_back('{abst_pkg::OP_INSERT, 16'h0000, 1'b1, abst_pkg::ST_DONE, 8'd2, 1});
    rows.push_back('{abst_pkg::OP_INSERT, 16'hFFFF, 1'b1, abst_pkg::ST_DONE, 8'd3, 1});
    rows.push_back('{abst_pkg::OP_SEARCH, 16'hFFFF, 1'b1, abst_pkg::ST_DONE, 8'd3, 1});
    rows.push_back('{abst_pkg::OP_INSERT, 16'h4000, 1'b0, abst_pkg::ST_DONE, 8'd0, 0});
    rows.push_back('{abst_pkg::OP_INSERT, 16'h2000, 1'b0, abst_pkg::ST_DONE, 8'd0, 0});
    rows.push_back('{abst_pkg::OP_INSERT, 16'hC000, 1'b0, abst_pkg::ST_DONE, 8'd0, 0});
    rows.push_back('{abst_pkg::OP_INSERT, 16'hA000, 1'b0, abst_pkg::ST_DONE, 8'd0, 0});
    rows.push_back('{abst_pkg::OP_INSERT, 16'hE000, 1'b0, abst_pkg::ST_DONE, 8'd0, 0});
    // Right child only, left child only, two children, missing key, key left unreachable.
    rows.push_back('{abst_pkg::OP_DELETE, 16'h0000, 1'b0, abst_pkg::ST_DONE, 8'd0, 0});
    rows.push_back('{abst_pkg::OP_DELETE, 16'hFFFF, 1'b0, abst_pkg::ST_DONE, 8'd0, 0});
    rows.push_back('{abst_pkg::OP_DELETE, 16'h8000, 1'b0, abst_pkg::ST_DONE, 8'd0, 0});
    rows.push_back('{abst_pkg::OP_DELETE, 16'h5555, 1'b0, abst_pkg::ST_DONE, 8'd0, 0});
    rows.push_back('{abst_pkg::OP_DELETE, 16'h2000, 1'b0, abst_pkg::ST_DONE, 8'd0, 0});
    rows.push_back('{abst_pkg::OP_SEARCH, 16'hAAAA, 1'b0, abst_pkg::ST_DONE, 8'd0, 0});
    rows.push_back('{abst_pkg::OP_HEIGHT, 16'hFFFF, 1'b0, abst_pkg::ST_DONE, 8'd0, 0});
    foreach (rows[i]) begin
      row = rows[i];
      send_request(row.op, row.key);
      got = pending_results[$];
      if (row.typed && (got.status != row.st || got.slot_index != row.slot ||
                        got.tree_height != 4'(row.ht))) begin
        $display("%0t: row %0d expected %0d %0d %0d, predicted %0d %0d %0d", $time, i,
                 row.st, row.slot, row.ht, got.status, got.slot_index, got.tree_height);
        errors++;
      end
    end
    drain_results();

    // Ascending inserts build a right spine that runs past the store (full).
    for (int i = 0; i < 10; i++) send_request(abst_pkg::OP_INSERT, 16'(16'h7000 + i));
    for (int i = 0; i < 10; i++) send_request(abst_pkg::OP_DELETE, 16'(16'h7000 + i));

    n = 0;
    while (n < 1000) begin
      calm = (n >= 400 && n < 550);
      if (n == 700) drain_results();
      if ($urandom_range(99) < 8) begin
        // A run of keys moving outward from a random base, above or below it, deepens the tree.
        base = 16'($urandom);
        for (int k = 0; k < 9 && n < 1000; k++) begin
          send_request(abst_pkg::OP_INSERT, 16'(base + ($urandom_range(1) ? k : -k)));
          n++;
        end
      end else begin
        // Keys mostly near existing ones, so deletes and duplicates hit.
        key = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(63) << 10);
        case ($urandom_range(9))
          0, 1, 2, 3: send_request(abst_pkg::OP_INSERT, key);
          4, 5, 6:    send_request(abst_pkg::OP_DELETE, key);
          7, 8:       send_request(abst_pkg::OP_SEARCH, key);
          default:    send_request(abst_pkg::OP_HEIGHT, 16'($urandom));
        endcase
        n++;
      end
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Checked %0d results: %0d inserts, %0d deletes, %0d searches, %0d height.",
             results_seen, ops_sent[abst_pkg::OP_INSERT], ops_sent[abst_pkg::OP_DELETE],
             ops_sent[abst_pkg::OP_SEARCH], ops_sent[abst_pkg::OP_HEIGHT]);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
